// ===== rtl/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types, widths and register codes for the trackball motion scaler.
// ----------------------------------------------------------------------------
package tms_pkg;

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LAYER_W    = 4;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned THRESH_W   = 15;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned REM_W      = 9;
  localparam int unsigned MOVE_W     = 8;
  localparam int unsigned STEP_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = THRESH_W;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_SHIFT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_SHIFT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [SHIFT_W-1:0]  COARSE_SHIFT_RST    = 4'd6;
  localparam logic [SHIFT_W-1:0]  FINE_SHIFT_RST      = 4'd8;
  localparam logic [THRESH_W-1:0] ACCEL_THRESHOLD_RST = 15'd400;

  // largest divisor exponent, keeps the remainder inside 9 bits
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;

  // layer masks
  localparam logic [LAYER_W-1:0] LAYER_POINTER = 4'b0000;
  localparam logic [LAYER_W-1:0] LAYER_FINE    = 4'b0010;
  localparam logic [LAYER_W-1:0] LAYER_SCROLL  = 4'b0100;

  // motion byte flag for new motion
  localparam int unsigned MOTION_BIT = 7;

  // scroll step codes
  localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
  localparam logic signed [STEP_W-1:0] STEP_POS  = 2'sb01;
  localparam logic signed [STEP_W-1:0] STEP_NEG  = 2'sb11;

  // configuration register set
  typedef struct packed {
    logic [SHIFT_W-1:0]  coarse_shift;
    logic [SHIFT_W-1:0]  fine_shift;
    logic [THRESH_W-1:0] accel_threshold;
  } cfg_t;

endpackage

// ===== rtl/tms_if.sv =====
// ----------------------------------------------------------------------------
// tms channel interfaces
// Sensor read channel, report channel and configuration write channel.
// ----------------------------------------------------------------------------

// sensor read channel
interface tms_sensor_if;
  logic                        valid;
  logic                        ready;
  logic [tms_pkg::BYTE_W-1:0]  motion_status;
  logic [tms_pkg::BYTE_W-1:0]  x_low_byte;
  logic [tms_pkg::BYTE_W-1:0]  y_low_byte;
  logic [tms_pkg::BYTE_W-1:0]  high_nibbles;
  logic [tms_pkg::BYTE_W-1:0]  button_bits;
  logic [tms_pkg::LAYER_W-1:0] layer_bits;

  modport source (output valid, motion_status, x_low_byte, y_low_byte, high_nibbles,
                  button_bits, layer_bits, input ready);
  modport sink (input valid, motion_status, x_low_byte, y_low_byte, high_nibbles,
                button_bits, layer_bits, output ready);
endinterface

// mouse report channel
interface tms_report_if;
  logic                              valid;
  logic                              ready;
  logic                              report_due;
  logic [tms_pkg::BYTE_W-1:0]        report_buttons;
  logic signed [tms_pkg::MOVE_W-1:0] move_x;
  logic signed [tms_pkg::MOVE_W-1:0] move_y;
  logic signed [tms_pkg::STEP_W-1:0] scroll_h;
  logic signed [tms_pkg::STEP_W-1:0] scroll_v;

  modport source (output valid, report_due, report_buttons, move_x, move_y, scroll_h,
                  scroll_v, input ready);
  modport sink (input valid, report_due, report_buttons, move_x, move_y, scroll_h,
                scroll_v, output ready);
endinterface

// configuration write channel
interface tms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tms_pkg::CFG_IDX_W-1:0]  index;
  logic [tms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tms_cfg_regs
// Configuration register file: divisor exponents and acceleration threshold.
// ----------------------------------------------------------------------------
module tms_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  tms_cfg_if.sink        cfg,
  output tms_pkg::cfg_t  regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coarse_shift    <= tms_pkg::COARSE_SHIFT_RST;
      regs.fine_shift      <= tms_pkg::FINE_SHIFT_RST;
      regs.accel_threshold <= tms_pkg::ACCEL_THRESHOLD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tms_pkg::REG_COARSE_SHIFT:    regs.coarse_shift <= cfg.data[tms_pkg::SHIFT_W-1:0];
        tms_pkg::REG_FINE_SHIFT:      regs.fine_shift   <= cfg.data[tms_pkg::SHIFT_W-1:0];
        tms_pkg::REG_ACCEL_THRESHOLD: regs.accel_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tms_axis.sv =====
// ----------------------------------------------------------------------------
// tms_axis
// One motion axis: remainder carry, truncating power-of-two divide,
// acceleration, saturation and scroll sign.
// ----------------------------------------------------------------------------
module tms_axis (
  input  logic signed [tms_pkg::DELTA_W-1:0]  delta,
  input  logic signed [tms_pkg::REM_W-1:0]    remainder,
  input  logic [tms_pkg::SHIFT_W-1:0]         shift,
  input  logic [tms_pkg::THRESH_W-1:0]        threshold,
  input  logic                                scroll,
  output logic signed [tms_pkg::REM_W-1:0]    remainder_next,
  output logic signed [tms_pkg::MOVE_W-1:0]   move,
  output logic signed [tms_pkg::STEP_W-1:0]   step
);

  localparam int unsigned SUM_W = tms_pkg::DELTA_W + 2;
  localparam int unsigned ACC_W = SUM_W + 1;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] bias;
  logic signed [SUM_W-1:0] quot;
  logic signed [SUM_W-1:0] rem_full;
  logic signed [SUM_W-1:0] delta_ext;
  logic signed [SUM_W-1:0] thresh_ext;
  logic                    fast;
  logic signed [ACC_W-1:0] accel;
  logic signed [tms_pkg::MOVE_W-1:0] sat;

  // carry in the kept remainder
  assign delta_ext = SUM_W'(delta);
  assign sum       = delta_ext + SUM_W'(remainder);

  // round toward zero: negative sums get divisor minus one added first
  assign bias     = sum[SUM_W-1] ? ((SUM_W'(1) << shift) - SUM_W'(1)) : '0;
  assign quot     = (sum + bias) >>> shift;
  assign rem_full = sum - (quot <<< shift);
  assign remainder_next = rem_full[tms_pkg::REM_W-1:0];

  // doubling above the speed threshold
  assign thresh_ext = SUM_W'($signed({1'b0, threshold}));
  assign fast  = (delta_ext > thresh_ext) || (delta_ext < -thresh_ext);
  assign accel = fast ? (ACC_W'(quot) <<< 1) : ACC_W'(quot);

  // clamp to a signed byte
  always_comb begin
    priority if (accel > ACC_W'(127)) begin
      sat = 8'sd127;
    end else if (accel < -ACC_W'(128)) begin
      sat = -8'sd128;
    end else begin
      sat = accel[tms_pkg::MOVE_W-1:0];
    end
  end

  // pointer movement or scroll sign
  always_comb begin
    if (scroll) begin
      move = '0;
      priority if (quot > 0) begin
        step = tms_pkg::STEP_POS;
      end else if (quot < 0) begin
        step = tms_pkg::STEP_NEG;
      end else begin
        step = tms_pkg::STEP_NONE;
      end
    end else begin
      move = sat;
      step = tms_pkg::STEP_NONE;
    end
  end

endmodule

// ===== rtl/trackball_motion_scaler.sv =====
// ----------------------------------------------------------------------------
// trackball_motion_scaler
// Turns trackball sensor reads into mouse reports with remainder carry,
// power-of-two scaling, acceleration and a scroll mode.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      carries
//  sensor   in   valid / ready  motion byte, packed deltas, buttons, layer
//  report   out  valid / ready  report flag, buttons, movement, scroll steps
//  cfg      in   valid / ready  register index, write data (always ready)
//
//  A request is captured in an input register, and scaled on its way into
//  the result register, which raises report valid. One request per cycle
//  sustained while the report side is ready; the remainder and button
//  registers are updated as each request moves into the result register.
//  A stalled report holds one request in the input register, after that the
//  sensor side is held off. Synchronous reset clears valid flags and state.
// ----------------------------------------------------------------------------
module trackball_motion_scaler (
  input  logic         clk,
  input  logic         rst,
  tms_sensor_if.sink   sensor,
  tms_report_if.source report,
  tms_cfg_if.sink      cfg
);

  tms_pkg::cfg_t regs;

  // input register
  logic                        in_valid;
  logic [tms_pkg::BYTE_W-1:0]  in_motion;
  logic [tms_pkg::BYTE_W-1:0]  in_x_low;
  logic [tms_pkg::BYTE_W-1:0]  in_y_low;
  logic [tms_pkg::BYTE_W-1:0]  in_high;
  logic [tms_pkg::BYTE_W-1:0]  in_buttons;
  logic [tms_pkg::LAYER_W-1:0] in_layer;

  // kept state
  logic signed [tms_pkg::REM_W-1:0] x_remainder;
  logic signed [tms_pkg::REM_W-1:0] y_remainder;
  logic [tms_pkg::BYTE_W-1:0]       prev_buttons;
  logic                             scroll_mode;

  logic                             advance;
  logic signed [tms_pkg::DELTA_W-1:0] dx;
  logic signed [tms_pkg::DELTA_W-1:0] dy;
  logic                             scroll_mode_next;
  logic [tms_pkg::SHIFT_W-1:0]      shift_sel;
  logic [tms_pkg::SHIFT_W-1:0]      shift;
  logic signed [tms_pkg::REM_W-1:0] x_remainder_next;
  logic signed [tms_pkg::REM_W-1:0] y_remainder_next;
  logic signed [tms_pkg::MOVE_W-1:0] move_x_next;
  logic signed [tms_pkg::MOVE_W-1:0] move_y_next;
  logic signed [tms_pkg::STEP_W-1:0] step_h;
  logic signed [tms_pkg::STEP_W-1:0] step_y;
  logic                             report_due_next;

  tms_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // handshake: input stage moves on when the result register is free
  assign advance      = in_valid && (!report.valid || report.ready);
  assign sensor.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sensor.ready) begin
      in_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.valid && sensor.ready) begin
      in_motion  <= sensor.motion_status;
      in_x_low   <= sensor.x_low_byte;
      in_y_low   <= sensor.y_low_byte;
      in_high    <= sensor.high_nibbles;
      in_buttons <= sensor.button_bits;
      in_layer   <= sensor.layer_bits;
    end
  end

  // unpack the 12-bit deltas into 16-bit values
  assign dx = {in_high[7:4], in_x_low, 4'b0000};
  assign dy = {in_high[3:0], in_y_low, 4'b0000};

  // layer decode: mode and divisor exponent
  always_comb begin
    scroll_mode_next = scroll_mode;
    shift_sel        = regs.coarse_shift;
    unique case (in_layer)
      tms_pkg::LAYER_POINTER: scroll_mode_next = 1'b0;
      tms_pkg::LAYER_SCROLL:  scroll_mode_next = 1'b1;
      tms_pkg::LAYER_FINE: begin
        scroll_mode_next = 1'b0;
        shift_sel        = regs.fine_shift;
      end
      default: ;
    endcase
  end

  assign shift = (shift_sel > tms_pkg::MAX_SHIFT) ? tms_pkg::MAX_SHIFT : shift_sel;

  tms_axis u_axis_x (
    .delta          (dx),
    .remainder      (x_remainder),
    .shift          (shift),
    .threshold      (regs.accel_threshold),
    .scroll         (scroll_mode_next),
    .remainder_next (x_remainder_next),
    .move           (move_x_next),
    .step           (step_h)
  );

  tms_axis u_axis_y (
    .delta          (dy),
    .remainder      (y_remainder),
    .shift          (shift),
    .threshold      (regs.accel_threshold),
    .scroll         (scroll_mode_next),
    .remainder_next (y_remainder_next),
    .move           (move_y_next),
    .step           (step_y)
  );

  // report on button change or new motion
  assign report_due_next = (in_buttons != prev_buttons) || in_motion[tms_pkg::MOTION_BIT];

  // kept state follows each request into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      x_remainder  <= '0;
      y_remainder  <= '0;
      prev_buttons <= '0;
      scroll_mode  <= 1'b0;
    end else if (advance) begin
      x_remainder  <= x_remainder_next;
      y_remainder  <= y_remainder_next;
      prev_buttons <= in_buttons;
      scroll_mode  <= scroll_mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (advance) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      report.report_due     <= report_due_next;
      report.report_buttons <= in_buttons;
      report.move_x         <= move_x_next;
      report.move_y         <= move_y_next;
      report.scroll_h       <= step_h;
      report.scroll_v       <= tms_pkg::STEP_NONE - step_y;
    end
  end

  // scroll steps and pointer movement never appear together
  assert property (@(posedge clk) disable iff (rst)
    report.valid && (report.scroll_h != tms_pkg::STEP_NONE ||
                     report.scroll_v != tms_pkg::STEP_NONE)
    |-> report.move_x == '0 && report.move_y == '0)
    else $error("scroll step reported together with pointer movement");

  // scroll steps stay within minus one to one
  assert property (@(posedge clk) disable iff (rst)
    report.valid |-> report.scroll_h != 2'b10 && report.scroll_v != 2'b10)
    else $error("scroll step out of range");

  // a button change always raises the report flag
  assert property (@(posedge clk) disable iff (rst)
    advance && (in_buttons != prev_buttons) |=> report.valid && report.report_due)
    else $error("button change without report flag");

  // kept remainders stay below the largest divisor in magnitude
  assert property (@(posedge clk) disable iff (rst)
    x_remainder != 9'h100 && y_remainder != 9'h100)
    else $error("remainder out of range");

endmodule

// ===== tb/tb_trackball_motion_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trackball_motion_scaler
// Drives sensor reads into the motion scaler and checks every mouse report
// against a cycle-free predictor that keeps its own residues, button history,
// scroll mode and register copies. Register writes happen only with the
// block drained; idle and stall mixes on both channels vary per phase.
// ----------------------------------------------------------------------------
module tb_trackball_motion_scaler;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_LIMIT  = 40;
  localparam int unsigned BURST_ITEMS  = 150;

  // layer masks that leave the mode alone
  localparam logic [tms_pkg::LAYER_W-1:0] LAYER_KEEP_LOW = 4'b0001;
  localparam logic [tms_pkg::LAYER_W-1:0] LAYER_KEEP_MIX = 4'b0110;
  localparam logic [tms_pkg::LAYER_W-1:0] LAYER_KEEP_ALL = 4'b1111;
  // register index with no register behind it
  localparam logic [tms_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // motion byte values
  localparam logic [tms_pkg::BYTE_W-1:0] MOTION_NEW  = 8'h80;
  localparam logic [tms_pkg::BYTE_W-1:0] MOTION_NONE = 8'h00;
  localparam logic [tms_pkg::BYTE_W-1:0] MOTION_LOW  = 8'h7F;

  typedef struct packed {
    logic [tms_pkg::BYTE_W-1:0]  motion_status;
    logic [tms_pkg::BYTE_W-1:0]  x_low_byte;
    logic [tms_pkg::BYTE_W-1:0]  y_low_byte;
    logic [tms_pkg::BYTE_W-1:0]  high_nibbles;
    logic [tms_pkg::BYTE_W-1:0]  button_bits;
    logic [tms_pkg::LAYER_W-1:0] layer_bits;
  } sensor_read_t;

  typedef struct packed {
    logic                              report_due;
    logic [tms_pkg::BYTE_W-1:0]        report_buttons;
    logic signed [tms_pkg::MOVE_W-1:0] move_x;
    logic signed [tms_pkg::MOVE_W-1:0] move_y;
    logic signed [tms_pkg::STEP_W-1:0] scroll_h;
    logic signed [tms_pkg::STEP_W-1:0] scroll_v;
  } mouse_report_t;

  logic clk;
  logic rst;

  tms_sensor_if sensor_ch ();
  tms_report_if report_ch ();
  tms_cfg_if    cfg_ch ();

  trackball_motion_scaler i_dut (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor_ch),
    .report (report_ch),
    .cfg    (cfg_ch)
  );

  // predictor state and register copies
  int            x_carry;
  int            y_carry;
  logic [tms_pkg::BYTE_W-1:0] last_buttons;
  bit            scrolling;
  int unsigned   coarse_exp;
  int unsigned   fine_exp;
  int            accel_limit;

  mouse_report_t pending_reports[$];
  logic [tms_pkg::BYTE_W-1:0] buttons_sent;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned reads_sent;
  int unsigned reports_checked;
  int unsigned register_writes;
  int unsigned scroll_reports;
  int unsigned cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout: %0d reports still pending", pending_reports.size());
      $display("FAILURE");
      $finish;
    end
  end

  // report side back-pressure
  always @(posedge clk) begin
    report_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [tms_pkg::MOVE_W-1:0] clamp_move(int q);
    if (q > 127) return 8'sd127;
    if (q < -128) return -8'sd128;
    return q[tms_pkg::MOVE_W-1:0];
  endfunction

  function automatic logic signed [tms_pkg::STEP_W-1:0] step_of(int q);
    if (q > 0) return tms_pkg::STEP_POS;
    if (q < 0) return tms_pkg::STEP_NEG;
    return tms_pkg::STEP_NONE;
  endfunction

  // scale one sensor read, advancing the predictor state
  function automatic mouse_report_t predict_report(sensor_read_t r);
    mouse_report_t res;
    logic signed [tms_pkg::DELTA_W-1:0] dx16;
    logic signed [tms_pkg::DELTA_W-1:0] dy16;
    int dx;
    int dy;
    int sx;
    int sy;
    int qx;
    int qy;
    int divisor;
    int unsigned exp_sel;
    dx16 = {r.high_nibbles[7:4], r.x_low_byte, 4'b0000};
    dy16 = {r.high_nibbles[3:0], r.y_low_byte, 4'b0000};
    dx = 32'(dx16);
    dy = 32'(dy16);
    res = '0;
    res.report_due = (r.button_bits != last_buttons) ||
                     r.motion_status[tms_pkg::MOTION_BIT];
    res.report_buttons = r.button_bits;
    last_buttons = r.button_bits;
    // mode and divisor selection
    exp_sel = coarse_exp;
    if (r.layer_bits == tms_pkg::LAYER_POINTER) begin
      scrolling = 1'b0;
    end else if (r.layer_bits == tms_pkg::LAYER_SCROLL) begin
      scrolling = 1'b1;
    end else if (r.layer_bits == tms_pkg::LAYER_FINE) begin
      scrolling = 1'b0;
      exp_sel = fine_exp;
    end
    if (exp_sel > 32'(tms_pkg::MAX_SHIFT)) exp_sel = 32'(tms_pkg::MAX_SHIFT);
    divisor = 1 << exp_sel;
    // truncating division, residue keeps the dividend sign
    sx = dx + x_carry;
    sy = dy + y_carry;
    qx = sx / divisor;
    qy = sy / divisor;
    x_carry = sx % divisor;
    y_carry = sy % divisor;
    if (!scrolling) begin
      if (dx > accel_limit || dx < -accel_limit) qx = qx * 2;
      if (dy > accel_limit || dy < -accel_limit) qy = qy * 2;
      res.move_x = clamp_move(qx);
      res.move_y = clamp_move(qy);
    end else begin
      res.scroll_h = step_of(qx);
      res.scroll_v = step_of(-qy);
    end
    return res;
  endfunction

  // report checker
  always @(posedge clk) begin
    mouse_report_t want;
    if (!rst && report_ch.valid && report_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("report with none pending, move_x", report_ch.move_x, 0);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (report_ch.report_due !== want.report_due)
          report_mismatch("report_due", report_ch.report_due, want.report_due);
        if (report_ch.report_buttons !== want.report_buttons)
          report_mismatch("report_buttons", report_ch.report_buttons, want.report_buttons);
        if (report_ch.move_x !== want.move_x)
          report_mismatch("move_x", report_ch.move_x, want.move_x);
        if (report_ch.move_y !== want.move_y)
          report_mismatch("move_y", report_ch.move_y, want.move_y);
        if (report_ch.scroll_h !== want.scroll_h)
          report_mismatch("scroll_h", report_ch.scroll_h, want.scroll_h);
        if (report_ch.scroll_v !== want.scroll_v)
          report_mismatch("scroll_v", report_ch.scroll_v, want.scroll_v);
      end
    end
  end

  function automatic sensor_read_t make_read(logic [tms_pkg::BYTE_W-1:0] motion,
                                             int x12, int y12,
                                             logic [tms_pkg::BYTE_W-1:0] buttons,
                                             logic [tms_pkg::LAYER_W-1:0] layer);
    sensor_read_t r;
    r.motion_status = motion;
    r.x_low_byte    = x12[7:0];
    r.y_low_byte    = y12[7:0];
    r.high_nibbles  = {x12[11:8], y12[11:8]};
    r.button_bits   = buttons;
    r.layer_bits    = layer;
    return r;
  endfunction

  // one sensor request, with random idle cycles ahead of it
  task automatic send_read(sensor_read_t r);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      sensor_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sensor_ch.valid         <= 1'b1;
    sensor_ch.motion_status <= r.motion_status;
    sensor_ch.x_low_byte    <= r.x_low_byte;
    sensor_ch.y_low_byte    <= r.y_low_byte;
    sensor_ch.high_nibbles  <= r.high_nibbles;
    sensor_ch.button_bits   <= r.button_bits;
    sensor_ch.layer_bits    <= r.layer_bits;
    do @(posedge clk); while (!sensor_ch.ready);
    pending_reports.push_back(predict_report(r));
    buttons_sent = r.button_bits;
    reads_sent++;
    if (scrolling) scroll_reports++;
  endtask

  // hold the sensor side until every pending report is out
  task automatic wait_reports_drained();
    sensor_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(logic [tms_pkg::CFG_IDX_W-1:0] idx,
                                logic [tms_pkg::CFG_DATA_W-1:0] value);
    wait_reports_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      tms_pkg::REG_COARSE_SHIFT:    coarse_exp = 32'(value[tms_pkg::SHIFT_W-1:0]);
      tms_pkg::REG_FINE_SHIFT:      fine_exp = 32'(value[tms_pkg::SHIFT_W-1:0]);
      tms_pkg::REG_ACCEL_THRESHOLD: accel_limit = 32'(value);
      default: ;
    endcase
    register_writes++;
  endtask

  // sensor delta of 12 bits, mostly small, sometimes extreme
  function automatic int pick_delta12();
    case ($urandom_range(3))
      0: return $urandom_range(16) - 8;
      1: return $urandom_range(127) - 64;
      2: return $urandom_range(4095) - 2048;
      default: return $urandom_range(1) ? 2047 : -2048;
    endcase
  endfunction

  function automatic sensor_read_t random_read();
    logic [tms_pkg::LAYER_W-1:0] layer;
    logic [tms_pkg::BYTE_W-1:0]  buttons;
    case ($urandom_range(9))
      0, 1, 2: layer = tms_pkg::LAYER_POINTER;
      3, 4:    layer = tms_pkg::LAYER_SCROLL;
      5, 6:    layer = tms_pkg::LAYER_FINE;
      default: layer = tms_pkg::LAYER_W'($urandom_range(15));
    endcase
    // buttons often held so that reports are not always due
    buttons = $urandom_range(1) ? buttons_sent : tms_pkg::BYTE_W'($urandom_range(255));
    return make_read(tms_pkg::BYTE_W'($urandom_range(255)), pick_delta12(), pick_delta12(),
                     buttons, layer);
  endfunction

  function automatic int unsigned pick_shift();
    case ($urandom_range(3))
      0: return 0;
      1: return 32'(tms_pkg::MAX_SHIFT);
      2: return 15;
      default: return $urandom_range(15);
    endcase
  endfunction

  // random register set, junk in the unused upper data bits of the shifts
  task automatic apply_random_settings();
    logic [tms_pkg::CFG_DATA_W-1:0] junk;
    junk = tms_pkg::CFG_DATA_W'($urandom_range(32767));
    write_register(tms_pkg::REG_COARSE_SHIFT,
                   {junk[tms_pkg::CFG_DATA_W-1:tms_pkg::SHIFT_W], 4'(pick_shift())});
    junk = tms_pkg::CFG_DATA_W'($urandom_range(32767));
    write_register(tms_pkg::REG_FINE_SHIFT,
                   {junk[tms_pkg::CFG_DATA_W-1:tms_pkg::SHIFT_W], 4'(pick_shift())});
    case ($urandom_range(3))
      0: write_register(tms_pkg::REG_ACCEL_THRESHOLD, '0);
      1: write_register(tms_pkg::REG_ACCEL_THRESHOLD, 15'h7FFF);
      2: write_register(tms_pkg::REG_ACCEL_THRESHOLD,
                        tms_pkg::CFG_DATA_W'($urandom_range(2000)));
      default: write_register(tms_pkg::REG_ACCEL_THRESHOLD,
                              tms_pkg::CFG_DATA_W'($urandom_range(32767)));
    endcase
  endtask

  // hand-picked reads under the reset register values
  task automatic test_directed_reads();
    send_read(make_read(MOTION_NONE, 0, 0, 8'h00, tms_pkg::LAYER_POINTER));
    send_read(make_read(MOTION_NEW, 1, -1, 8'h00, tms_pkg::LAYER_POINTER));
    // residue carries into a whole count
    send_read(make_read(MOTION_NEW, 3, -3, 8'h00, tms_pkg::LAYER_POINTER));
    // largest and smallest deltas saturate
    send_read(make_read(MOTION_NEW, 2047, 2047, 8'h00, tms_pkg::LAYER_POINTER));
    send_read(make_read(MOTION_NEW, -2048, -2048, 8'h00, tms_pkg::LAYER_POINTER));
    // report due on button change only, then on nothing
    send_read(make_read(MOTION_NONE, 0, 0, 8'h01, tms_pkg::LAYER_POINTER));
    send_read(make_read(MOTION_LOW, 0, 0, 8'h01, tms_pkg::LAYER_POINTER));
    // right at the threshold, then just beyond it
    send_read(make_read(8'hFF, 25, -25, 8'hFF, tms_pkg::LAYER_POINTER));
    send_read(make_read(MOTION_NEW, 26, -26, 8'hFF, tms_pkg::LAYER_POINTER));
    // fine divisor, then an unlisted mask falls back to coarse
    send_read(make_read(MOTION_NEW, 20, 20, 8'h00, tms_pkg::LAYER_FINE));
    send_read(make_read(MOTION_NEW, 20, 20, 8'h00, LAYER_KEEP_LOW));
    // scroll mode, kept by unlisted masks
    send_read(make_read(MOTION_NEW, 100, 100, 8'h10, tms_pkg::LAYER_SCROLL));
    send_read(make_read(MOTION_NEW, -100, -100, 8'h10, LAYER_KEEP_ALL));
    send_read(make_read(MOTION_NEW, 1, 1, 8'h10, tms_pkg::LAYER_SCROLL));
    send_read(make_read(MOTION_NEW, 2047, -2048, 8'h10, LAYER_KEEP_MIX));
    // back to pointer, negative residues build up
    send_read(make_read(MOTION_NEW, 0, 0, 8'hAA, tms_pkg::LAYER_POINTER));
    repeat (4) send_read(make_read(MOTION_NEW, -1, -1, 8'h55, tms_pkg::LAYER_POINTER));
    send_read(make_read(MOTION_NEW, 255, -256, 8'h55, LAYER_KEEP_MIX));
  endtask

  // smallest and largest register values, short random bursts each
  task automatic test_register_extremes();
    write_register(tms_pkg::REG_COARSE_SHIFT, '0);
    write_register(tms_pkg::REG_FINE_SHIFT, '0);
    write_register(tms_pkg::REG_ACCEL_THRESHOLD, '0);
    repeat (30) send_read(random_read());
    write_register(tms_pkg::REG_COARSE_SHIFT, 15'h7FFF);
    write_register(tms_pkg::REG_FINE_SHIFT, 15'h5559);
    write_register(tms_pkg::REG_ACCEL_THRESHOLD, 15'h7FFF);
    write_register(REG_UNUSED, 15'h2A5A);
    repeat (30) send_read(random_read());
    write_register(tms_pkg::REG_COARSE_SHIFT, tms_pkg::CFG_DATA_W'(tms_pkg::MAX_SHIFT));
    write_register(tms_pkg::REG_FINE_SHIFT, tms_pkg::CFG_DATA_W'(tms_pkg::MAX_SHIFT));
    write_register(tms_pkg::REG_ACCEL_THRESHOLD, tms_pkg::ACCEL_THRESHOLD_RST);
    repeat (30) send_read(random_read());
  endtask

  // random reads under one idle mix, register set changed per burst
  task automatic test_random_traffic(int unsigned sender_idle, int unsigned receiver_stall,
                                     int unsigned n_reads);
    wait_reports_drained();
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    for (int unsigned i = 0; i < n_reads; i++) begin
      if (i % BURST_ITEMS == 0) apply_random_settings();
      send_read(random_read());
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    sensor_ch.valid         <= 1'b0;
    sensor_ch.motion_status <= '0;
    sensor_ch.x_low_byte    <= '0;
    sensor_ch.y_low_byte    <= '0;
    sensor_ch.high_nibbles  <= '0;
    sensor_ch.button_bits   <= '0;
    sensor_ch.layer_bits    <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= '0;
    cfg_ch.data             <= '0;
    idle_pct        = 0;
    stall_pct       = 0;
    mismatches      = 0;
    reads_sent      = 0;
    reports_checked = 0;
    register_writes = 0;
    scroll_reports  = 0;
    x_carry         = 0;
    y_carry         = 0;
    last_buttons    = '0;
    buttons_sent    = '0;
    scrolling       = 1'b0;
    coarse_exp      = 32'(tms_pkg::COARSE_SHIFT_RST);
    fine_exp        = 32'(tms_pkg::FINE_SHIFT_RST);
    accel_limit     = 32'(tms_pkg::ACCEL_THRESHOLD_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_reads();
    test_register_extremes();
    test_random_traffic(0, 0, 450);
    test_random_traffic(56, 0, 450);
    test_random_traffic(0, 56, 450);
    test_random_traffic(31, 31, 450);

    wait_reports_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d sensor reads (%0d in scroll mode), %0d reports, %0d register writes",
             reads_sent, scroll_reports, reports_checked, register_writes);
    $display("idle mixes none / sender / receiver / both; shifts 0 to 15, thresholds to 32767");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
